// ===== rtl/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg: shared types and constants for the telemetry frame parser
// parse phase encoding, frame constants and the bytewise crc-8 update
// ----------------------------------------------------------------------------
package crsf_pkg;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_CRC    = 4'b1000
    } phase_t;

    localparam logic [7:0] SYNC_RESET = 8'hEA;
    localparam logic [7:0] VARIO_TYPE = 8'h07;
    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] LEN_MIN    = 8'd2;
    localparam logic [7:0] BYTE_ALL1  = 8'hFF;
    localparam int         HEAD_DEPTH = 3;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/crsf_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// crsf_frame_parser_top: sync-framed telemetry parser with crc-8 check
// takes one received byte per transfer, returns one result per good frame
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle, back to back, while the output
// is not stalled: the byte is first captured in an input register, then the
// phase, payload count, running crc-8 and the three head bytes are updated in
// a single pass and a result is loaded into the output register. The parser
// hunts for the sync byte (cfg_wr_data, reset 0xEA), reads a length byte (2
// to MAX_FRAME-2, else back to the hunt), collects length-1 payload bytes and
// compares the next byte with the crc (polynomial 0xD5, initial value 0). A
// good frame gives frame_type; a vario frame (type 0x07) also gives the
// big-endian signed vertical speed in cm/s, with speed_valid low when both
// speed bytes are 0xFF. A crc mismatch gives no result. The output register
// holds a result until res_ready takes it; while a result waits, the parser
// holds the next byte in its input register, and rx_ready falls only when
// both the input and output registers are full and the output is stalled.
// Write the sync address only while the parser is idle.
// ----------------------------------------------------------------------------
module crsf_frame_parser_top #(
    parameter int MAX_FRAME = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    // received bytes
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    // results
    output logic               res_valid,
    input  logic               res_ready,
    output logic [7:0]         frame_type,
    output logic signed [15:0] vertical_speed,
    output logic               speed_valid
);

    // payload count and target width, target never exceeds MAX_FRAME-3
    localparam int         CNT_W   = $clog2(MAX_FRAME);
    localparam logic [8:0] LEN_MAX = 9'(MAX_FRAME - 2);

    // sync address register
    logic [7:0] sync_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    crsf_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] target_reg, target_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       head_reg [crsf_pkg::HEAD_DEPTH];

    // output register
    logic               out_valid_reg;
    logic [7:0]         type_reg;
    logic signed [15:0] speed_reg;
    logic               spd_ok_reg;

    logic             advance;
    logic             emit;
    logic             head_we;
    logic [1:0]       head_idx;
    logic [CNT_W-1:0] count_inc;
    logic             is_vario;

    // the input register moves on when the output register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || res_ready);
    assign rx_ready = !in_valid_reg || advance;

    assign count_inc = count_reg + CNT_W'(1);
    assign is_vario  = (head_reg[0] == crsf_pkg::VARIO_TYPE);

    // phase and counter update for the byte in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        target_next = target_reg;
        crc_next    = crc_reg;
        emit        = 1'b0;
        head_we     = 1'b0;
        head_idx    = count_reg[1:0];
        if (advance)
        begin
            unique case (phase_reg)
                crsf_pkg::PH_HUNT:
                begin
                    if (in_byte_reg == sync_reg)
                        phase_next = crsf_pkg::PH_LENGTH;
                end
                crsf_pkg::PH_LENGTH:
                begin
                    // bad length is dropped, not rescanned as a sync byte
                    if (in_byte_reg < crsf_pkg::LEN_MIN || {1'b0, in_byte_reg} > LEN_MAX)
                    begin
                        phase_next = crsf_pkg::PH_HUNT;
                    end
                    else
                    begin
                        target_next = CNT_W'(in_byte_reg - 8'd1);
                        count_next  = '0;
                        crc_next    = '0;
                        phase_next  = crsf_pkg::PH_DATA;
                    end
                end
                crsf_pkg::PH_DATA:
                begin
                    // only the first three payload bytes are kept
                    head_we    = (count_reg < CNT_W'(crsf_pkg::HEAD_DEPTH));
                    count_next = count_inc;
                    crc_next   = crsf_pkg::crc8_update(crc_reg, in_byte_reg);
                    if (count_inc >= target_reg)
                        phase_next = crsf_pkg::PH_CRC;
                end
                crsf_pkg::PH_CRC:
                begin
                    phase_next = crsf_pkg::PH_HUNT;
                    emit       = (crc_reg == in_byte_reg);
                end
                default:
                begin
                    phase_next = crsf_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= crsf_pkg::SYNC_RESET;
            in_valid_reg  <= 1'b0;
            phase_reg     <= crsf_pkg::PH_HUNT;
            count_reg     <= '0;
            target_reg    <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                sync_reg <= cfg_wr_data;
            if (rx_ready)
                in_valid_reg <= rx_valid;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            target_reg <= target_next;
            crc_reg    <= crc_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
            in_byte_reg <= rx_byte;
        if (head_we)
            head_reg[head_idx] <= in_byte_reg;
        if (emit)
        begin
            type_reg <= head_reg[0];
            if (is_vario)
            begin
                speed_reg  <= {head_reg[1], head_reg[2]};
                spd_ok_reg <= (head_reg[1] != crsf_pkg::BYTE_ALL1) ||
                              (head_reg[2] != crsf_pkg::BYTE_ALL1);
            end
            else
            begin
                speed_reg  <= '0;
                spd_ok_reg <= 1'b0;
            end
        end
    end

    assign res_valid      = out_valid_reg;
    assign frame_type     = type_reg;
    assign vertical_speed = speed_reg;
    assign speed_valid    = spd_ok_reg;

    // a new result only follows a crc byte
    a_emit_after_crc: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == crsf_pkg::PH_CRC))
        else $error("result produced outside the crc phase");

    // speed is only flagged for vario frames
    a_speed_vario: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && speed_valid) |-> (frame_type == crsf_pkg::VARIO_TYPE))
        else $error("speed_valid set on a non-vario frame");

    // payload count stays below its target while collecting
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == crsf_pkg::PH_DATA) |-> (count_reg < target_reg))
        else $error("payload count reached target inside data phase");

endmodule
